// ----- rtl/trt_pkg.sv -----
// Shared constants, widths and the arctangent table of the touch rotation tracker.
package trt_pkg;

    // Sizing
    localparam int TRAIL_MAX_N  = 160;
    localparam int CORDIC_STEPS = 16;
    localparam int TAB_LEN      = 24;
    localparam int SQRT_STEPS   = 10;
    localparam int LOOP_N       = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
    localparam int CNT_W        = $clog2(LOOP_N + 1);
    localparam int TAB_IDX_W    = 5;

    // Field widths
    localparam int COORD_W = 9;
    localparam int DIFF_W  = 10;
    localparam int RAD_W   = 10;
    localparam int SQ_W    = 20;
    localparam int ANG_W   = 15;
    localparam int DANG_W  = 16;
    localparam int TURN_W  = 32;
    localparam int DEG_W   = 26;
    localparam int PTS_W   = 8;

    // CORDIC datapath
    localparam int CX_FRAC = 16;
    localparam int CX_W    = 29;
    localparam int Z_W     = 24;
    localparam int Q_W     = Z_W - 8;

    localparam logic signed [Z_W-1:0]    HALF_TURN_Z = 24'sd2949120;
    localparam logic signed [Z_W-1:0]    Z_ROUND     = 24'sd128;
    localparam logic signed [Q_W-1:0]    ANG_HALF_Q  = 16'sd11520;
    localparam logic signed [Q_W-1:0]    ANG_NHALF_Q = -16'sd11520;
    localparam logic signed [DANG_W-1:0] ANG_HALF_D  = 16'sd11520;
    localparam logic signed [DANG_W-1:0] ANG_NHALF_D = -16'sd11520;
    localparam logic signed [DANG_W-1:0] ANG_FULL_D  = 16'sd23040;

    localparam logic [PTS_W-1:0] TRAIL_MAX = PTS_W'(TRAIL_MAX_N);
    localparam logic [SQ_W-1:0]  SQ_BIT0   = SQ_W'(1) << (2 * (SQRT_STEPS - 1));

    localparam logic signed [TURN_W-1:0] TURN_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [TURN_W-1:0] TURN_MIN = 32'sh8000_0000;

    // Configuration registers
    localparam int REG_IDX_W = 2;
    localparam int PADDR_W   = 4;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_X    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_Y    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_EDGE_RADIUS = 2'd2;

    localparam logic [COORD_W-1:0] CENTER_X_RST    = 9'd180;
    localparam logic [COORD_W-1:0] CENTER_Y_RST    = 9'd180;
    localparam logic [RAD_W-1:0]   EDGE_RADIUS_RST = 10'd130;

    // atan(2^-i) in units of 2^-14 degree, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        unique case (idx)
            5'd0:    v = 24'sd737280;
            5'd1:    v = 24'sd435242;
            5'd2:    v = 24'sd229970;
            5'd3:    v = 24'sd116736;
            5'd4:    v = 24'sd58595;
            5'd5:    v = 24'sd29326;
            5'd6:    v = 24'sd14667;
            5'd7:    v = 24'sd7334;
            5'd8:    v = 24'sd3667;
            5'd9:    v = 24'sd1833;
            5'd10:   v = 24'sd917;
            5'd11:   v = 24'sd458;
            5'd12:   v = 24'sd229;
            5'd13:   v = 24'sd115;
            5'd14:   v = 24'sd57;
            5'd15:   v = 24'sd29;
            5'd16:   v = 24'sd14;
            5'd17:   v = 24'sd7;
            5'd18:   v = 24'sd4;
            5'd19:   v = 24'sd2;
            5'd20:   v = 24'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/touch_rotation_tracker.sv -----
// Touch rotation tracker: radius, edge flag, polar angle and unwrapped turn of a touch.
//
// One touch sample per input transaction gives one result transaction. An untouched
// sample goes from IDLE straight to FIN; a touched sample passes through SQX, SQY, EDGE,
// the iterative ITER loop and ANG before FIN. In each ITER cycle the shared shift/add
// unit does one vectoring CORDIC step while, for the first SQRT_STEPS of them, a
// digit-by-digit square root retires one bit of radius. Before the loop one shared
// 10x10 squarer forms dx^2, dy^2 and edge_radius^2 in SQX, SQY and EDGE. o_ready is
// high only while the sequencer is idle; the result sits in an output register, so the
// next sample is taken while an earlier result still waits for i_ready. Configuration
// goes through the APB port (center_x at 0x0, center_y at 0x4, edge_radius at 0x8) and
// may only be written while no sample is in flight. Angles are in 1/64 degree on screen
// axes (clockwise positive); a touch exactly at the centre reads as angle zero.
module touch_rotation_tracker
    import trt_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // sample channel
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_touch_down,
    input  logic [COORD_W-1:0]       i_pos_x,
    input  logic [COORD_W-1:0]       i_pos_y,
    // result channel
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [RAD_W-1:0]         o_radius,
    output logic                     o_at_edge,
    output logic signed [ANG_W-1:0]  o_angle,
    output logic signed [DEG_W-1:0]  o_turn_degrees,
    output logic [PTS_W-1:0]         o_point_count,
    output logic                     o_pressed,
    // configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    // Sequencer codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQX  = 3'd1;  // square dx
    localparam logic [2:0] ST_SQY  = 3'd2;  // add dy squared, seed CORDIC
    localparam logic [2:0] ST_EDGE = 3'd3;  // compare with edge radius squared, seed sqrt
    localparam logic [2:0] ST_ITER = 3'd4;  // shared CORDIC / sqrt loop
    localparam logic [2:0] ST_ANG  = 3'd5;  // round and clamp the angle
    localparam logic [2:0] ST_FIN  = 3'd6;  // unwrap, accumulate, load result

    logic [2:0] r_state, n_state;

    // Configuration registers
    logic [COORD_W-1:0] r_center_x, r_center_y;
    logic [RAD_W-1:0]   r_edge_radius;

    // Tracking state
    logic                     r_was_pressed;
    logic signed [ANG_W-1:0]  r_prev_angle;
    logic signed [TURN_W-1:0] r_turn_total;
    logic [PTS_W-1:0]         r_samples;

    // Working registers of one sample
    logic                     r_down;
    logic signed [DIFF_W-1:0] r_dx, r_dy;
    logic [SQ_W-1:0]          r_d2;
    logic                     r_edge;
    logic [SQ_W-1:0]          r_sq_v, r_sq_res, r_sq_bit;
    logic signed [CX_W-1:0]   r_x, r_y;
    logic signed [Z_W-1:0]    r_z;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [ANG_W-1:0]  r_ang;

    // Output register
    logic                     r_out_valid;
    logic [RAD_W-1:0]         r_out_radius;
    logic                     r_out_edge;
    logic signed [ANG_W-1:0]  r_out_angle;
    logic signed [DEG_W-1:0]  r_out_deg;
    logic [PTS_W-1:0]         r_out_points;
    logic                     r_out_pressed;

    logic in_fire, out_free, fin_fire, cfg_write;

    assign o_ready   = (r_state == ST_IDLE);
    assign in_fire   = i_valid && o_ready;
    assign out_free  = !r_out_valid || i_ready;
    assign fin_fire  = (r_state == ST_FIN) && out_free;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x    <= CENTER_X_RST;
            r_center_y    <= CENTER_Y_RST;
            r_edge_radius <= EDGE_RADIUS_RST;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_CENTER_X:    r_center_x    <= pwdata[COORD_W-1:0];
                REG_CENTER_Y:    r_center_y    <= pwdata[COORD_W-1:0];
                REG_EDGE_RADIUS: r_edge_radius <= pwdata[RAD_W-1:0];
                default:         ;  // unmapped address: drop the write
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_CENTER_X:    prdata = {{(32-COORD_W){1'b0}}, r_center_x};
            REG_CENTER_Y:    prdata = {{(32-COORD_W){1'b0}}, r_center_y};
            REG_EDGE_RADIUS: prdata = {{(32-RAD_W){1'b0}}, r_edge_radius};
            default:         prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Shared squarer: |dx|, |dy| or edge radius, one per cycle
    // ---------------------------------------------------------------
    logic [RAD_W-1:0] sq_op;
    logic [SQ_W-1:0]  sq_p;

    always_comb begin
        unique case (r_state)
            ST_SQX:  sq_op = r_dx[DIFF_W-1] ? RAD_W'(-r_dx) : RAD_W'(r_dx);
            ST_SQY:  sq_op = r_dy[DIFF_W-1] ? RAD_W'(-r_dy) : RAD_W'(r_dy);
            default: sq_op = r_edge_radius;
        endcase
    end

    assign sq_p = sq_op * sq_op;

    // ---------------------------------------------------------------
    // CORDIC seed: fold the left half plane onto the right
    // ---------------------------------------------------------------
    logic signed [DIFF_W-1:0] seed_x, seed_y;
    logic signed [Z_W-1:0]    seed_z;

    always_comb begin
        if (r_dx[DIFF_W-1]) begin
            seed_x = -r_dx;
            seed_y = -r_dy;
            seed_z = r_dy[DIFF_W-1] ? -HALF_TURN_Z : HALF_TURN_Z;
        end else begin
            seed_x = r_dx;
            seed_y = r_dy;
            seed_z = '0;
        end
    end

    // ---------------------------------------------------------------
    // Loop step: one CORDIC rotation and one square-root digit
    // ---------------------------------------------------------------
    logic                   cordic_on, sqrt_on, loop_last;
    logic signed [CX_W-1:0] x_sh, y_sh, n_x, n_y;
    logic signed [Z_W-1:0]  tab_val, n_z;
    logic [SQ_W:0]          sq_trial;
    logic [SQ_W-1:0]        n_sq_v, n_sq_res;

    assign cordic_on = (r_cnt < CNT_W'(CORDIC_STEPS));
    assign sqrt_on   = (r_cnt < CNT_W'(SQRT_STEPS));
    assign loop_last = (r_cnt == CNT_W'(LOOP_N - 1));
    assign x_sh      = r_x >>> r_cnt;
    assign y_sh      = r_y >>> r_cnt;
    assign tab_val   = atan_entry(TAB_IDX_W'(r_cnt));

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        if (cordic_on) begin
            if (!r_y[CX_W-1]) begin
                n_x = r_x + y_sh;
                n_y = r_y - x_sh;
                n_z = r_z + tab_val;
            end else begin
                n_x = r_x - y_sh;
                n_y = r_y + x_sh;
                n_z = r_z - tab_val;
            end
        end
    end

    assign sq_trial = {1'b0, r_sq_res} + {1'b0, r_sq_bit};

    always_comb begin
        n_sq_v   = r_sq_v;
        n_sq_res = r_sq_res;
        if (sqrt_on) begin
            if ({1'b0, r_sq_v} >= sq_trial) begin
                n_sq_v   = SQ_W'({1'b0, r_sq_v} - sq_trial);
                n_sq_res = (r_sq_res >> 1) + r_sq_bit;
            end else begin
                n_sq_res = r_sq_res >> 1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Angle rounding and clamp; minus half turn reads as plus half turn
    // ---------------------------------------------------------------
    logic signed [Z_W-1:0]   z_rnd;
    logic signed [Q_W-1:0]   ang_q;
    logic signed [ANG_W-1:0] n_ang;

    assign z_rnd = (r_z + Z_ROUND) >>> 8;
    assign ang_q = z_rnd[Q_W-1:0];

    always_comb begin
        if (r_dx == '0 && r_dy == '0) begin
            n_ang = '0;
        end else if (ang_q > ANG_HALF_Q || ang_q <= ANG_NHALF_Q) begin
            n_ang = ANG_W'(ANG_HALF_Q);
        end else begin
            n_ang = ang_q[ANG_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Unwrap, saturating turn total, point count, degree conversion
    // ---------------------------------------------------------------
    logic signed [DANG_W-1:0] d_raw, d_unw;
    logic signed [TURN_W:0]   turn_sum;
    logic signed [TURN_W-1:0] turn_acc, n_turn, deg_bias;
    logic [PTS_W-1:0]         n_samples;

    assign d_raw = DANG_W'(r_ang) - DANG_W'(r_prev_angle);

    always_comb begin
        if (d_raw > ANG_HALF_D) begin
            d_unw = d_raw - ANG_FULL_D;
        end else if (d_raw <= ANG_NHALF_D) begin
            d_unw = d_raw + ANG_FULL_D;
        end else begin
            d_unw = d_raw;
        end
    end

    assign turn_sum = (TURN_W + 1)'(r_turn_total) + (TURN_W + 1)'(d_unw);

    always_comb begin
        if (turn_sum[TURN_W] != turn_sum[TURN_W-1]) begin
            turn_acc = turn_sum[TURN_W] ? TURN_MIN : TURN_MAX;
        end else begin
            turn_acc = turn_sum[TURN_W-1:0];
        end
    end

    always_comb begin
        n_turn    = r_turn_total;
        n_samples = r_samples;
        if (r_down) begin
            if (!r_was_pressed) begin
                // new press: clear the total and restart the count
                n_turn    = '0;
                n_samples = PTS_W'(1);
            end else begin
                n_turn    = turn_acc;
                n_samples = (r_samples < TRAIL_MAX) ? r_samples + PTS_W'(1) : r_samples;
            end
        end
    end

    // truncate toward zero: bias negatives by 63 before the shift
    assign deg_bias = n_turn + (n_turn[TURN_W-1] ? TURN_W'(63) : TURN_W'(0));

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_fire) n_state = i_touch_down ? ST_SQX : ST_FIN;
            ST_SQX:  n_state = ST_SQY;
            ST_SQY:  n_state = ST_EDGE;
            ST_EDGE: n_state = ST_ITER;
            ST_ITER: if (loop_last) n_state = ST_ANG;
            ST_ANG:  n_state = ST_FIN;
            ST_FIN:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_was_pressed <= 1'b0;
            r_prev_angle  <= '0;
            r_turn_total  <= '0;
            r_samples     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fin_fire) begin
                r_was_pressed <= r_down;
                r_turn_total  <= n_turn;
                r_samples     <= n_samples;
                if (r_down) begin
                    r_prev_angle <= r_ang;
                end
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working and result payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_down <= i_touch_down;
            r_dx   <= DIFF_W'({1'b0, i_pos_x}) - DIFF_W'({1'b0, r_center_x});
            r_dy   <= DIFF_W'({1'b0, i_pos_y}) - DIFF_W'({1'b0, r_center_y});
        end
        unique case (r_state)
            ST_SQX: r_d2 <= sq_p;
            ST_SQY: begin
                r_d2 <= r_d2 + sq_p;
                r_x  <= {{(CX_W-DIFF_W-CX_FRAC){seed_x[DIFF_W-1]}}, seed_x, {CX_FRAC{1'b0}}};
                r_y  <= {{(CX_W-DIFF_W-CX_FRAC){seed_y[DIFF_W-1]}}, seed_y, {CX_FRAC{1'b0}}};
                r_z  <= seed_z;
            end
            ST_EDGE: begin
                r_edge   <= (r_d2 >= sq_p);
                r_sq_v   <= r_d2;
                r_sq_res <= '0;
                r_sq_bit <= SQ_BIT0;
                r_cnt    <= '0;
            end
            ST_ITER: begin
                r_x      <= n_x;
                r_y      <= n_y;
                r_z      <= n_z;
                r_sq_v   <= n_sq_v;
                r_sq_res <= n_sq_res;
                r_sq_bit <= r_sq_bit >> 2;
                r_cnt    <= r_cnt + CNT_W'(1);
            end
            ST_ANG: r_ang <= n_ang;
            default: ;  // hold
        endcase
        if (fin_fire) begin
            r_out_radius  <= r_down ? r_sq_res[RAD_W-1:0] : '0;
            r_out_edge    <= r_down && r_edge;
            r_out_angle   <= r_down ? r_ang : '0;
            r_out_deg     <= deg_bias[TURN_W-1:TURN_W-DEG_W];
            r_out_points  <= n_samples;
            r_out_pressed <= r_down;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_radius       = r_out_radius;
    assign o_at_edge      = r_out_edge;
    assign o_angle        = r_out_angle;
    assign o_turn_degrees = r_out_deg;
    assign o_point_count  = r_out_points;
    assign o_pressed      = r_out_pressed;

endmodule

// ----- sim/trt_result_checker.sv -----
// Result checker for the touch rotation tracker: tracks register writes, predicts and compares results.
`timescale 1ns / 100ps
module trt_result_checker
    import trt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic                    i_touch_down,
    input  logic [COORD_W-1:0]      i_pos_x,
    input  logic [COORD_W-1:0]      i_pos_y,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic [RAD_W-1:0]        i_radius,
    input  logic                    i_at_edge,
    input  logic signed [ANG_W-1:0] i_angle,
    input  logic signed [DEG_W-1:0] i_turn_degrees,
    input  logic [PTS_W-1:0]        i_point_count,
    input  logic                    i_pressed,
    input  logic                    i_psel,
    input  logic                    i_penable,
    input  logic                    i_pwrite,
    input  logic                    i_pready,
    input  logic [PADDR_W-1:0]      i_paddr,
    input  logic [31:0]             i_pwdata,
    output int                      o_fail_count,
    output int                      o_pending
);

    localparam int     CX_AT_RESET   = 180;
    localparam int     CY_AT_RESET   = 180;
    localparam int     EDGE_AT_RESET = 130;
    localparam int     HALF_TURN_Q6  = 11520;
    localparam int     FULL_TURN_Q6  = 23040;
    localparam longint HALF_TURN_Z14 = 180 * 16384;
    localparam longint TURN_CEIL     = 64'sh7FFF_FFFF;
    localparam longint TURN_FLOOR    = -64'sh8000_0000;

    typedef struct packed {
        logic [RAD_W-1:0]        radius;
        logic                    at_edge;
        logic signed [ANG_W-1:0] angle;
        logic signed [DEG_W-1:0] turn_deg;
        logic [PTS_W-1:0]        points;
        logic                    pressed;
    } polar_result_t;

    // atan(2^-i) in 2^-14 degree
    int atan_q14 [0:23] = '{737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
                            3667, 1833, 917, 458, 229, 115, 57, 29,
                            14, 7, 4, 2, 1, 0, 0, 0};

    polar_result_t expected_polar_q[$];
    polar_result_t head_result;

    int     cen_x;
    int     cen_y;
    int     edge_rad;
    bit     touch_prev;
    int     last_angle;
    longint turn_acc;
    int     held_count;
    int     fail_total = 0;

    function automatic int floor_sqrt(input int v);
        int root;
        root = 0;
        for (int b = 9; b >= 0; b--)
            if ((root + (1 << b)) * (root + (1 << b)) <= v)
                root += 1 << b;
        return root;
    endfunction

    // Vectoring CORDIC; result in 1/64 degree, -180 folds to +180
    function automatic int cordic_angle(input int dx, input int dy);
        longint x, y, z, xs, ys, q;
        if (dx == 0 && dy == 0)
            return 0;
        x = dx;
        y = dy;
        z = 0;
        if (dx < 0) begin
            x = -x;
            y = -y;
            z = (dy >= 0) ? HALF_TURN_Z14 : -HALF_TURN_Z14;
        end
        x = x * 65536;
        y = y * 65536;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys;
                y -= xs;
                z += atan_q14[i];
            end else begin
                x -= ys;
                y += xs;
                z -= atan_q14[i];
            end
        end
        q = (z + 128) >>> 8;
        if (q > HALF_TURN_Q6)
            q = HALF_TURN_Q6;
        if (q <= -HALF_TURN_Q6)
            q = HALF_TURN_Q6;
        return int'(q);
    endfunction

    function automatic polar_result_t predict_polar(input logic td,
                                                    input logic [COORD_W-1:0] px,
                                                    input logic [COORD_W-1:0] py);
        polar_result_t r;
        int dx, dy, d2, ang;
        longint dang;
        r = '0;
        r.pressed = td;
        if (td) begin
            dx = int'(px) - cen_x;
            dy = int'(py) - cen_y;
            d2 = dx * dx + dy * dy;
            ang = cordic_angle(dx, dy);
            r.radius  = RAD_W'(floor_sqrt(d2));
            r.at_edge = (d2 >= edge_rad * edge_rad);
            r.angle   = ANG_W'(ang);
            if (!touch_prev) begin
                held_count = 0;
                turn_acc   = 0;
            end else begin
                dang = ang - last_angle;
                if (dang > HALF_TURN_Q6)
                    dang -= FULL_TURN_Q6;
                if (dang <= -HALF_TURN_Q6)
                    dang += FULL_TURN_Q6;
                turn_acc += dang;
                if (turn_acc > TURN_CEIL)
                    turn_acc = TURN_CEIL;
                if (turn_acc < TURN_FLOOR)
                    turn_acc = TURN_FLOOR;
            end
            last_angle = ang;
            if (held_count < TRAIL_MAX_N)
                held_count++;
        end
        touch_prev = td;
        r.turn_deg = DEG_W'(turn_acc / 64);
        r.points   = PTS_W'(held_count);
        return r;
    endfunction

    task automatic note_mismatch(input string field, input longint want, input longint got);
        fail_total++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cen_x      = CX_AT_RESET;
            cen_y      = CY_AT_RESET;
            edge_rad   = EDGE_AT_RESET;
            touch_prev = 1'b0;
            last_angle = 0;
            turn_acc   = 0;
            held_count = 0;
            expected_polar_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_polar_q.size() == 0) begin
                    fail_total++;
                    $display("%0t: unexpected result, expected none, got radius %0d angle %0d",
                             $time, i_radius, i_angle);
                end else begin
                    head_result = expected_polar_q.pop_front();
                    if (i_radius !== head_result.radius)
                        note_mismatch("radius", head_result.radius, i_radius);
                    if (i_at_edge !== head_result.at_edge)
                        note_mismatch("at_edge", head_result.at_edge, i_at_edge);
                    if (i_angle !== head_result.angle)
                        note_mismatch("angle", head_result.angle, i_angle);
                    if (i_turn_degrees !== head_result.turn_deg)
                        note_mismatch("turn_degrees", head_result.turn_deg, i_turn_degrees);
                    if (i_point_count !== head_result.points)
                        note_mismatch("point_count", head_result.points, i_point_count);
                    if (i_pressed !== head_result.pressed)
                        note_mismatch("pressed", head_result.pressed, i_pressed);
                end
            end
            if (i_in_valid && i_in_ready)
                expected_polar_q.push_back(predict_polar(i_touch_down, i_pos_x, i_pos_y));
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[PADDR_W-1:2])
                    REG_CENTER_X:    cen_x    = int'(i_pwdata[COORD_W-1:0]);
                    REG_CENTER_Y:    cen_y    = int'(i_pwdata[COORD_W-1:0]);
                    REG_EDGE_RADIUS: edge_rad = int'(i_pwdata[RAD_W-1:0]);
                    default: ;
                endcase
            end
        end
        o_pending    <= expected_polar_q.size();
        o_fail_count <= fail_total;
    end

endmodule

// ----- sim/touch_rotation_tracker_tb.sv -----
// Testbench top for the touch rotation tracker: stimulus, handshake pacing and verdict.
`timescale 1ns / 100ps
module touch_rotation_tracker_tb
    import trt_pkg::*;
();

    // Index with no register behind it; writes there must be ignored.
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Longest stretch without any transaction before the run is declared hung.
    localparam int QUIET_LIMIT = 2000;
    // Cycles to keep watching the result channel once nothing is outstanding.
    localparam int TAIL_CYCLES = 40;
    localparam int PHASE_ITEMS = 290;

    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_valid      = 1'b0;
    logic                    i_touch_down = 1'b0;
    logic [COORD_W-1:0]      i_pos_x      = '0;
    logic [COORD_W-1:0]      i_pos_y      = '0;
    logic                    i_ready      = 1'b0;
    logic                    psel         = 1'b0;
    logic                    penable      = 1'b0;
    logic                    pwrite       = 1'b0;
    logic [PADDR_W-1:0]      paddr        = '0;
    logic [31:0]             pwdata       = '0;

    logic                    o_ready;
    logic                    o_valid;
    logic [RAD_W-1:0]        o_radius;
    logic                    o_at_edge;
    logic signed [ANG_W-1:0] o_angle;
    logic signed [DEG_W-1:0] o_turn_degrees;
    logic [PTS_W-1:0]        o_point_count;
    logic                    o_pressed;
    logic [31:0]             prdata;
    logic                    pready;

    int mismatch_count;
    int pending_results;
    int quiet_cycles   = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cfg_cx         = 180;
    int cfg_cy         = 180;

    touch_rotation_tracker dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_touch_down   (i_touch_down),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_radius       (o_radius),
        .o_at_edge      (o_at_edge),
        .o_angle        (o_angle),
        .o_turn_degrees (o_turn_degrees),
        .o_point_count  (o_point_count),
        .o_pressed      (o_pressed),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // The checker sees both channels and the register bus; it owns all prediction.
    trt_result_checker u_result_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_touch_down   (i_touch_down),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_radius       (o_radius),
        .i_at_edge      (o_at_edge),
        .i_angle        (o_angle),
        .i_turn_degrees (o_turn_degrees),
        .i_point_count  (o_point_count),
        .i_pressed      (o_pressed),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_fail_count   (mismatch_count),
        .o_pending      (pending_results)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver: stall at random with the current phase's rate, one draw per cycle.
    always @(posedge i_clk)
        i_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Watchdog: any transaction on either channel restarts the count.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one sample. Valid stays high from the previous transaction unless an
    // idle gap is drawn, so back-to-back samples never drop valid within a step.
    task automatic push_sample(input logic td, input int x, input int y);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_touch_down <= td;
        i_pos_x      <= COORD_W'(x);
        i_pos_y      <= COORD_W'(y);
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Hold the sender off until every outstanding result has been accepted.
    // Step the clock first so the checker has seen the last transaction.
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
    endtask

    // Setup then access phase; the bus is left selected so writes can chain.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    // Program all registers with junk in the unused upper bits; only call when idle.
    task automatic load_config(input int cx, input int cy, input int er, input bit poke_unused);
        cfg_cx = cx;
        cfg_cy = cy;
        write_reg(REG_CENTER_X,    ($urandom & ~32'h1FF) | cx);
        write_reg(REG_CENTER_Y,    ($urandom & ~32'h1FF) | cy);
        write_reg(REG_EDGE_RADIUS, ($urandom & ~32'h3FF) | er);
        if (poke_unused)
            write_reg(REG_UNUSED, $urandom);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One press tracing a square orbit around the centre. Mostly small steps so the
    // turn total grows smoothly; some large jumps land anywhere on the orbit to hit unwrap.
    task automatic run_stroke(input int n_samples);
        int r, perim, p, dir, step, side, off, x, y;
        r     = $urandom_range(255, 1);
        perim = 8 * r;
        p     = $urandom_range(perim - 1);
        dir   = $urandom_range(1) ? 1 : -1;
        repeat (n_samples) begin
            step = ($urandom_range(4) == 0) ? $urandom_range(perim - 1) : $urandom_range(r);
            p    = (p + dir * step + perim) % perim;
            side = p / (2 * r);
            off  = p % (2 * r) - r;
            case (side)
                0:       begin x = cfg_cx + r;   y = cfg_cy + off; end
                1:       begin x = cfg_cx - off; y = cfg_cy + r;   end
                2:       begin x = cfg_cx - r;   y = cfg_cy - off; end
                default: begin x = cfg_cx + off; y = cfg_cy - r;   end
            endcase
            x = (x < 0) ? 0 : (x > 511) ? 511 : x;
            y = (y < 0) ? 0 : (y > 511) ? 511 : y;
            push_sample(1'b1, x, y);
        end
    endtask

    // Mostly well-formed presses with releases, some raw noise. The first press of
    // each phase is long enough to drive the point count into saturation.
    task automatic run_random(input int n_items);
        int sent, len;
        bit first;
        sent  = 0;
        first = 1'b1;
        while (sent < n_items) begin
            if ($urandom_range(39) == 0)
                drain_results();
            if (first || $urandom_range(99) < 85) begin
                len = (first || $urandom_range(7) == 0) ? $urandom_range(260, 165)
                                                        : $urandom_range(40, 1);
                first = 1'b0;
                run_stroke(len);
                sent += len;
                len = $urandom_range(3);
                repeat (len) push_sample(1'b0, $urandom_range(511), $urandom_range(511));
                sent += len;
            end else begin
                len = $urandom_range(6, 1);
                repeat (len)
                    push_sample($urandom_range(1), $urandom_range(511), $urandom_range(511));
                sent += len;
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed samples against the reset configuration: centre (180,180), edge 130.
        push_sample(1'b0, 511, 511);    // untouched, all position bits set
        push_sample(1'b1, 180, 180);    // press exactly at the centre
        push_sample(1'b1, 511, 180);    // zero degrees, far right
        push_sample(1'b1, 180, 511);    // quarter turn clockwise
        push_sample(1'b1, 0, 180);      // half turn on the negative x axis
        push_sample(1'b1, 180, 0);      // minus a quarter turn
        push_sample(1'b1, 0, 181);      // just below the negative x axis
        push_sample(1'b1, 0, 179);      // cross the seam: unwrap adds a full turn
        push_sample(1'b1, 0, 181);      // and back: unwrap drops a full turn
        push_sample(1'b1, 310, 180);    // distance equal to the edge radius
        push_sample(1'b1, 309, 180);    // one pixel inside the edge
        push_sample(1'b0, 0, 0);        // release
        push_sample(1'b0, 255, 256);
        push_sample(1'b1, 0, 0);        // new press clears turn and count
        push_sample(1'b1, 511, 511);
        push_sample(1'b1, 0, 511);
        push_sample(1'b1, 511, 0);
        push_sample(1'b1, 181, 180);    // radius one
        push_sample(1'b1, 180, 180);    // centre while held
        push_sample(1'b0, 180, 180);
        push_sample(1'b1, 180, 180);

        // Random phases, each with its own configuration and pacing.
        for (int phase = 0; phase < 4; phase++) begin
            drain_results();
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    load_config(0, 0, 0, 1'b1);
                end
                1: begin
                    send_idle_pct  = 57;
                    recv_stall_pct = 0;
                    load_config(511, 511, 1023, 1'b0);
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 57;
                    load_config($urandom_range(511), $urandom_range(511),
                                $urandom_range(400), 1'b0);
                end
                default: begin
                    send_idle_pct  = 18;
                    recv_stall_pct = 18;
                    load_config($urandom_range(511), $urandom_range(511),
                                $urandom_range(1023), 1'b1);
                end
            endcase
            // Touch at the new centre first: zero radius and angle under this setting.
            push_sample(1'b1, cfg_cx, cfg_cy);
            push_sample(1'b0, cfg_cx, cfg_cy);
            run_random(PHASE_ITEMS);
        end

        // Let everything drain, then watch a little longer for stray results.
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
